/* sv/dttip_pkg.sv */
package dttip_pkg;

   localparam int ValueWidth = 64;
   localparam int ProdWidth  = ValueWidth + 4;
   localparam int CmdDepth   = 4;
   localparam int CmdPtrWidth = $clog2(CmdDepth);
   localparam int ResDepth   = 2;
   localparam int ResPtrWidth = $clog2(ResDepth);

   localparam logic [ValueWidth-1:0] ValueMask = '1;
   localparam logic [ValueWidth-1:0] SignedMax = ValueMask >> 1;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharPlus  = 8'h2b;
   localparam logic [7:0] CharMinus = 8'h2d;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0d;
   localparam logic [7:0] CharSpace = 8'h20;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusInvalid = 2'd1;
   localparam logic [1:0] StatusNoToken = 2'd2;

   typedef enum logic [2:0] {
      KindBlank,
      KindDigit,
      KindPlus,
      KindMinus,
      KindOther,
      KindEnd
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      logic       mode;
   } cmd_type;

endpackage

/* sv/dttip_front.sv */
module dttip_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [7:0]        char_code,
   input  logic              mode,
   input  logic              end_of_stream,
   output logic              cmd_push,
   output dttip_pkg::cmd_type cmd,
   input  logic              cmd_full
);
   import dttip_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in, class_cmd;
   logic    accept;

   always_comb begin
      class_cmd.mode  = mode;
      class_cmd.digit = 4'(char_code - CharZero);
      if (end_of_stream) begin
         class_cmd.kind = KindEnd;
      end else if ((char_code >= CharTab && char_code <= CharCr) || char_code == CharSpace) begin
         class_cmd.kind = KindBlank;
      end else if (char_code >= CharZero && char_code <= CharNine) begin
         class_cmd.kind = KindDigit;
      end else if (char_code == CharPlus) begin
         class_cmd.kind = KindPlus;
      end else if (char_code == CharMinus) begin
         class_cmd.kind = KindMinus;
      end else begin
         class_cmd.kind = KindOther;
      end
   end

   assign full     = valid_ff && cmd_full;
   assign accept   = push && !full;
   assign cmd_push = valid_ff;
   assign cmd      = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (accept) begin
         valid_in = 1'b1;
         cmd_in   = class_cmd;
      end else if (!cmd_full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end
endmodule

/* sv/dttip_cmd_queue.sv */
module dttip_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  dttip_pkg::cmd_type wr_cmd,
   input  logic               pop,
   output logic               empty,
   output dttip_pkg::cmd_type rd_cmd
);
   import dttip_pkg::*;

   cmd_type                mem_ff [CmdDepth];
   logic [CmdPtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CmdPtrWidth:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = count_ff == (CmdPtrWidth+1)'(CmdDepth);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (CmdPtrWidth+1)'(do_push) - (CmdPtrWidth+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
   end
endmodule

/* sv/dttip_back.sv */
module dttip_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_empty,
   input  dttip_pkg::cmd_type cmd,
   output logic               cmd_pop,
   output logic               empty,
   input  logic               pop,
   output logic [63:0]        number,
   output logic [1:0]         status
);
   import dttip_pkg::*;

   logic                  in_token_ff, in_token_in;
   logic                  uns_ff, uns_in;
   logic                  first_ff, first_in;
   logic                  neg_ff, neg_in;
   logic                  saw_ff, saw_in;
   logic                  valid_ff, valid_in;
   logic [ValueWidth-1:0] mag_ff, mag_in;

   logic [63:0]            res_num_ff [ResDepth];
   logic [1:0]             res_stat_ff [ResDepth];
   logic [ResPtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ResPtrWidth:0]   count_ff, count_in;

   logic                  go, emit, do_pop;
   logic [63:0]           emit_num;
   logic [1:0]            emit_stat;
   logic                  cur_uns, cur_first, cur_neg, cur_saw, cur_valid;
   logic [ValueWidth-1:0] cur_mag, neg_mag;
   logic [ProdWidth-1:0]  prod, limit, wide_mag;

   assign go      = !cmd_empty && count_ff != (ResPtrWidth+1)'(ResDepth);
   assign cmd_pop = go;
   assign empty   = count_ff == '0;
   assign do_pop  = pop && !empty;
   assign number  = res_num_ff[rd_ptr_ff];
   assign status  = res_stat_ff[rd_ptr_ff];

   // a fresh token starts from idle values with the mode of its first byte
   always_comb begin
      if (in_token_ff) begin
         cur_uns   = uns_ff;
         cur_first = first_ff;
         cur_neg   = neg_ff;
         cur_saw   = saw_ff;
         cur_valid = valid_ff;
         cur_mag   = mag_ff;
      end else begin
         cur_uns   = cmd.mode;
         cur_first = 1'b1;
         cur_neg   = 1'b0;
         cur_saw   = 1'b0;
         cur_valid = 1'b1;
         cur_mag   = '0;
      end
      wide_mag = ProdWidth'(cur_mag);
      prod     = (wide_mag << 3) + (wide_mag << 1) + ProdWidth'(cmd.digit);
      if (cur_uns) begin
         limit = ProdWidth'(ValueMask);
      end else begin
         limit = ProdWidth'(SignedMax) + ProdWidth'(cur_neg);
      end
      neg_mag = '0 - mag_ff;
   end

   always_comb begin
      emit_stat = StatusInvalid;
      emit_num  = '0;
      if (valid_ff && saw_ff) begin
         emit_stat = StatusOk;
         emit_num  = (neg_ff && !uns_ff) ? 64'(neg_mag) : 64'(mag_ff);
      end

      emit        = 1'b0;
      in_token_in = in_token_ff;
      uns_in      = uns_ff;
      first_in    = first_ff;
      neg_in      = neg_ff;
      saw_in      = saw_ff;
      valid_in    = valid_ff;
      mag_in      = mag_ff;

      if (go) begin
         if (cmd.kind == KindEnd || cmd.kind == KindBlank) begin
            if (cmd.kind == KindEnd) begin
               emit = 1'b1;
               if (!in_token_ff) begin
                  emit_stat = StatusNoToken;
                  emit_num  = '0;
               end
            end else begin
               emit = in_token_ff;
            end
            in_token_in = 1'b0;
            uns_in      = 1'b0;
            first_in    = 1'b1;
            neg_in      = 1'b0;
            saw_in      = 1'b0;
            valid_in    = 1'b1;
            mag_in      = '0;
         end else begin
            in_token_in = 1'b1;
            uns_in      = cur_uns;
            first_in    = 1'b0;
            neg_in      = cur_neg;
            saw_in      = cur_saw;
            valid_in    = cur_valid;
            mag_in      = cur_mag;
            case (cmd.kind)
               KindDigit: begin
                  saw_in = 1'b1;
                  if (cur_valid) begin
                     if (prod > limit) begin
                        valid_in = 1'b0;
                     end else begin
                        mag_in = prod[ValueWidth-1:0];
                     end
                  end
               end
               KindPlus, KindMinus: begin
                  if (!cur_uns && cur_first) begin
                     neg_in = cmd.kind == KindMinus;
                  end else begin
                     valid_in = 1'b0;
                  end
               end
               default: begin
                  valid_in = 1'b0;
               end
            endcase
         end
      end

      wr_ptr_in = emit ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (ResPtrWidth+1)'(emit) - (ResPtrWidth+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff <= 1'b0;
         uns_ff      <= 1'b0;
         first_ff    <= 1'b1;
         neg_ff      <= 1'b0;
         saw_ff      <= 1'b0;
         valid_ff    <= 1'b1;
         mag_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_token_ff <= in_token_in;
         uns_ff      <= uns_in;
         first_ff    <= first_in;
         neg_ff      <= neg_in;
         saw_ff      <= saw_in;
         valid_ff    <= valid_in;
         mag_ff      <= mag_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
      if (emit) begin
         res_num_ff[wr_ptr_ff]  <= emit_num;
         res_stat_ff[wr_ptr_ff] <= emit_stat;
      end
   end
endmodule

/* sv/decimal_text_to_int64_parser_unit.sv */
// Parses whitespace-delimited decimal tokens from a byte stream into 64-bit
// values. One byte is taken per cycle while full is low; a byte is classified
// on entry, passes a four-entry request queue, and is folded into the running
// magnitude by a single multiply-by-ten, add and limit compare per cycle, so
// the sustained rate is one byte per clock while the result queue has room.
// The byte or end-of-stream request closing a token passes the front register
// and the request queue, and its result then waits in a two-entry result queue.
// Status 0 is ok, 1 an invalid or overflowing token, 2 an end of stream with no
// token in progress; number is zero unless status is ok.
module decimal_text_to_int64_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_char_code,
   input  logic        req_mode,
   input  logic        req_end_of_stream,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_number,
   output logic [1:0]  rsp_status
);
   import dttip_pkg::*;

   cmd_type front_cmd, queue_cmd;
   logic    front_push, queue_full, queue_empty, queue_pop;

   dttip_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .char_code     (req_char_code),
      .mode          (req_mode),
      .end_of_stream (req_end_of_stream),
      .cmd_push      (front_push),
      .cmd           (front_cmd),
      .cmd_full      (queue_full)
   );

   dttip_cmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (front_push),
      .full   (queue_full),
      .wr_cmd (front_cmd),
      .pop    (queue_pop),
      .empty  (queue_empty),
      .rd_cmd (queue_cmd)
   );

   dttip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (queue_empty),
      .cmd       (queue_cmd),
      .cmd_pop   (queue_pop),
      .empty     (empty),
      .pop       (pop),
      .number    (rsp_number),
      .status    (rsp_status)
   );
endmodule

/* sv/dttip_checker.sv */
module dttip_checker (
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [63:0] rsp_number,
   input logic [1:0]  rsp_status
);
   import dttip_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status == StatusOk || rsp_status == StatusInvalid ||
                  rsp_status == StatusNoToken))
      else $error("bad status code");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != StatusOk) |-> rsp_number == '0)
      else $error("nonzero number on error status");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (empty && !(push && !full)) [*8] |=> empty)
      else $error("result appeared without a request in flight");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_number) && $stable(rsp_status)))
      else $error("stalled result changed");
endmodule

bind decimal_text_to_int64_parser_unit dttip_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .push       (push),
   .full       (full),
   .empty      (empty),
   .pop        (pop),
   .rsp_number (rsp_number),
   .rsp_status (rsp_status)
);
